// ===== rtl/apft_pkg.sv =====
// Shared types, constants and helpers of the address prefix filter table.
// No dependencies; apft_front, apft_back and the top module import this package.
package apft_pkg;

	// Table geometry
	localparam int TableDepth = 64;
	localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CountW     = $clog2(TableDepth + 1);

	// Command queue between the front and the back
	localparam int QueueDepth = 2;
	localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QFillW     = $clog2(QueueDepth + 1);

	// Longest legal prefix
	localparam logic [7:0] MaxPrefix = 8'd128;

	// Opcodes on the input channel
	localparam logic [1:0] OpClear  = 2'd0;
	localparam logic [1:0] OpAdd    = 2'd1;
	localparam logic [1:0] OpLookup = 2'd2;

	typedef enum logic [1:0] {
		StDone      = 2'd0,
		StDuplicate = 2'd1,
		StFull      = 2'd2,
		StBadLength = 2'd3
	} status_t;

	// Command class decided by the front
	typedef enum logic [2:0] {
		KindNop       = 3'd0,
		KindClear     = 3'd1,
		KindAdd       = 3'd2,
		KindLookup    = 3'd3,
		KindBadLength = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [7:0]  prefix_length;
	} cmd_t;

	// One stored rule, as it sits in the table memory
	typedef struct packed {
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [7:0]  prefix_length;
	} rule_t;

	// Mask with the top len bits of a 128-bit address set (len at most 128)
	function automatic logic [127:0] top_mask(input logic [7:0] len);
		logic [8:0] sh;
		sh = {1'b0, MaxPrefix} - {1'b0, len};
		return ~128'd0 << sh;
	endfunction

endpackage

// ===== rtl/apft_if.sv =====
// Handshake channels of the address prefix filter table: command in, result out.
// Depends on nothing; widths follow the fixed field sizes.
interface apft_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [63:0] address_high;
	logic [63:0] address_low;
	logic [7:0]  prefix_length;

	modport source(output valid, output opcode, output address_high,
		output address_low, output prefix_length, input ready);
	modport sink(input valid, input opcode, input address_high,
		input address_low, input prefix_length, output ready);
endinterface

interface apft_out_if;
	logic       valid;
	logic       ready;
	logic       matched;
	logic [1:0] status;

	modport source(output valid, output matched, output status, input ready);
	modport sink(input valid, input matched, input status, output ready);
endinterface

// ===== rtl/apft_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the rule table.
module apft_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/apft_front.sv =====
// Front of the filter table: accepts commands, classifies them, queues them.
// Depends on apft_pkg and the apft_in_if channel.
module apft_front (
	input  logic           clk,
	input  logic           arst_n,
	apft_in_if.sink        item,
	output logic           q_valid,
	output apft_pkg::cmd_t q_cmd,
	input  logic           q_pop
);
	import apft_pkg::*;

	cmd_t             new_cmd;
	cmd_t             ent_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QFillW-1:0] fill_q;
	logic             push;

	// Classify the incoming command
	always_comb begin
		new_cmd.address_high  = item.address_high;
		new_cmd.address_low   = item.address_low;
		new_cmd.prefix_length = item.prefix_length;
		case (item.opcode)
			OpClear:  new_cmd.kind = KindClear;
			OpAdd:    new_cmd.kind = (item.prefix_length > MaxPrefix) ? KindBadLength : KindAdd;
			OpLookup: new_cmd.kind = KindLookup;
			default:  new_cmd.kind = KindNop;
		endcase
	end

	assign item.ready = (fill_q != QFillW'(QueueDepth));
	assign push       = item.valid && item.ready;
	assign q_valid    = (fill_q != '0);
	assign q_cmd      = ent_q[rd_ptr_q];

	// Store queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QFillW'(QueueDepth))
		else $error("queue fill level beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("push without pop did not grow the queue");

endmodule

// ===== rtl/apft_back.sv =====
// Back of the filter table: walks the rule memory one entry a cycle for adds
// and lookups, updates the table and holds the result. Uses apft_pkg,
// apft_out_if and apft_ram.
module apft_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  apft_pkg::cmd_t q_cmd,
	output logic           q_pop,
	apft_out_if.source     result
);
	import apft_pkg::*;

	typedef enum logic [2:0] {
		SIdle   = 3'b001,
		SScan   = 3'b010,
		SFinish = 3'b100
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [IdxW-1:0]   idx_q;
	logic              issue_q;
	logic              rd_vld_s1;
	logic              last_s1;
	logic              hit_q;
	logic [CountW-1:0] count_q;
	logic              out_valid_q;
	logic              matched_q;
	status_t           status_q;

	rule_t             rule_rd;
	rule_t             rule_wr;
	logic              ram_we;
	logic              issue_last;
	logic              exact;
	logic              covered;
	logic              hit;
	logic              slot_free;
	logic              out_load;
	logic              full;
	logic              fin_matched;
	status_t           fin_status;

	apft_ram #(
		.Width($bits(rule_t)),
		.Depth(TableDepth)
	) u_rules (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IdxW-1:0]),
		.wdata (rule_wr),
		.re    (issue_q),
		.raddr (idx_q),
		.rdata (rule_rd)
	);

	assign rule_wr = '{address_high: cmd_q.address_high, address_low: cmd_q.address_low,
		prefix_length: cmd_q.prefix_length};

	// Compare the entry read last cycle against the command
	assign exact   = (rule_rd == rule_wr);
	assign covered = ((({cmd_q.address_high, cmd_q.address_low}
		^ {rule_rd.address_high, rule_rd.address_low})
		& top_mask(rule_rd.prefix_length)) == '0);
	assign hit     = (cmd_q.kind == KindAdd) ? exact : covered;

	assign issue_last = ((CountW'(idx_q) + CountW'(1)) == count_q);
	assign full       = (count_q >= CountW'(TableDepth));
	assign q_pop      = q_valid && (state_q == SIdle);
	assign slot_free  = !out_valid_q || result.ready;
	assign out_load   = (state_q == SFinish) && slot_free;
	assign ram_we     = out_load && (cmd_q.kind == KindAdd) && !hit_q && !full;

	// Form the result of the finished command
	always_comb begin
		fin_matched = 1'b0;
		fin_status  = StDone;
		case (cmd_q.kind)
			KindBadLength: fin_status = StBadLength;
			KindAdd: begin
				if (hit_q) begin
					fin_status = StDuplicate;
				end else if (full) begin
					fin_status = StFull;
				end
			end
			KindLookup: fin_matched = hit_q;
			default: fin_status = StDone;
		endcase
	end

	// Sequence one command: start, scan, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SIdle;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
		end else begin
			case (state_q)
				SIdle: begin
					if (q_valid) begin
						if ((q_cmd.kind inside {KindAdd, KindLookup})
							&& count_q != '0) begin
							state_q <= SScan;
							issue_q <= 1'b1;
						end else begin
							state_q <= SFinish;
						end
					end
				end
				SScan: begin
					if (rd_vld_s1 && (hit || last_s1)) begin
						state_q   <= SFinish;
						issue_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
					end else begin
						rd_vld_s1 <= issue_q;
						if (issue_q && issue_last) begin
							issue_q <= 1'b0;
						end
					end
				end
				SFinish: begin
					if (slot_free) begin
						state_q <= SIdle;
						if (cmd_q.kind == KindClear) begin
							count_q <= '0;
						end else if (ram_we) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: state_q <= SIdle;
			endcase
		end
	end

	// Hold command, scan index and hit flag
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			idx_q <= '0;
			hit_q <= 1'b0;
		end else if (state_q == SScan) begin
			if (issue_q && !issue_last) begin
				idx_q <= idx_q + 1'b1;
			end
			if (issue_q) begin
				last_s1 <= issue_last;
			end
			if (rd_vld_s1) begin
				hit_q <= hit;
			end
		end
	end

	// Result register toward the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			matched_q <= fin_matched;
			status_q  <= fin_status;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.matched = matched_q;
	assign result.status  = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(TableDepth))
		else $error("rule count beyond table depth");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < CountW'(TableDepth)) && (state_q == SFinish))
		else $error("rule written into a full table");
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == SScan))
		else $error("read data flagged outside a scan");
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SScan) |-> count_q != '0)
		else $error("scan over an empty table");

endmodule

// ===== rtl/address_prefix_filter_table.sv =====
// Address prefix filter table: holds up to TableDepth 128-bit prefix rules and
// answers clear, add and lookup commands, one result per command.
//
// Channels: item carries opcode, address_high, address_low and prefix_length;
// result carries matched and status. Both transfer on valid and ready high.
// A two-entry command queue parts the input from the table sequencer, and a
// result register parts the sequencer from the receiver, so item keeps taking
// commands while a result waits.
// Sequence: a clear, a rejected add or an unused opcode passes from the queue
// straight to the finish state and the result register. An add or lookup
// reads the rule memory one entry a cycle over the stored rules, and stops
// early when a lookup hits or an add finds its duplicate. The single read
// port of the rule memory sets this rate.
// Reset empties the table and the queue at once; no clearing pass is needed.
// A receiver that stalls holds the result in place; the sequencer then waits
// and the queue fills, after which item drops ready.
module address_prefix_filter_table (
	input  logic       clk,
	input  logic       arst_n,
	apft_in_if.sink    item,
	apft_out_if.source result
);
	import apft_pkg::*;

	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	apft_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	apft_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for address_prefix_filter_table: clear, add and lookup commands
// are checked against a shadow copy of the rule store. Depends on rtl/apft_pkg.sv,
// rtl/apft_if.sv and rtl/address_prefix_filter_table.sv.
module testbench;
	import apft_pkg::*;

	// Opcode that the block ignores
	localparam logic [1:0] OpUnused = 2'd3;

	typedef struct {
		logic [1:0]   opcode;
		logic [127:0] address;
		logic [7:0]   prefix_length;
	} command_t;

	typedef struct {
		logic    matched;
		status_t status;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	apft_in_if  item_ch ();
	apft_out_if result_ch ();

	address_prefix_filter_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Shadow of the rule store
	logic [127:0] shadow_addr [TableDepth];
	logic [7:0]   shadow_len [TableDepth];
	int           shadow_count = 0;

	command_t command_q [$];
	verdict_t verdict_q [$];
	int       total_items = 0;
	int       sent_count = 0;
	int       error_count = 0;
	int       send_gap = 0;
	int       stall_left = 0;
	logic     long_hold = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Top len bits of a 128-bit address
	function automatic logic [127:0] prefix_mask(input logic [7:0] len);
		if (len == 8'd0) begin
			return '0;
		end
		return ~128'd0 << (128 - int'(len));
	endfunction

	function automatic logic [127:0] random_address();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic void push_command(input logic [1:0] op, input logic [127:0] addr,
		input logic [7:0] len);
		command_t cmd;
		cmd.opcode = op;
		cmd.address = addr;
		cmd.prefix_length = len;
		command_q.push_back(cmd);
	endfunction

	// Work out the result of one command and update the shadow store
	function automatic verdict_t table_verdict(input command_t cmd);
		verdict_t v;
		logic     dup;
		v.matched = 1'b0;
		v.status = StDone;
		dup = 1'b0;
		case (cmd.opcode)
			OpClear: begin
				shadow_count = 0;
			end
			OpAdd: begin
				if (cmd.prefix_length > MaxPrefix) begin
					v.status = StBadLength;
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						if (shadow_len[i] == cmd.prefix_length && shadow_addr[i] == cmd.address)
							dup = 1'b1;
					end
					if (dup) begin
						v.status = StDuplicate;
					end else if (shadow_count >= TableDepth) begin
						v.status = StFull;
					end else begin
						shadow_addr[shadow_count] = cmd.address;
						shadow_len[shadow_count] = cmd.prefix_length;
						shadow_count++;
					end
				end
			end
			OpLookup: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (((cmd.address ^ shadow_addr[i]) & prefix_mask(shadow_len[i])) == '0)
						v.matched = 1'b1;
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// Driver: present queued commands, predict on each transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				verdict_q.push_back(table_verdict(command_q.pop_front()));
				sent_count++;
			end
			// hold an offered command until it transfers
			if (!(item_ch.valid && !item_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (command_q.size() == 0) begin
					item_ch.valid <= 1'b0;
				end else if (sent_count < total_items - 150 && $urandom_range(0, 99) < 6) begin
					send_gap = $urandom_range(0, 18);
					item_ch.valid <= 1'b0;
				end else begin
					item_ch.valid <= 1'b1;
					item_ch.opcode <= command_q[0].opcode;
					item_ch.address_high <= command_q[0].address[127:64];
					item_ch.address_low <= command_q[0].address[63:0];
					item_ch.prefix_length <= command_q[0].prefix_length;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction
	always @(posedge clk) begin : monitor
		verdict_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (verdict_q.size() == 0) begin
					$error("result transfer with no command outstanding");
					error_count++;
				end else begin
					want = verdict_q.pop_front();
					if (result_ch.matched !== want.matched) begin
						$error("matched: expected %0d, actual %0d", want.matched,
							result_ch.matched);
						error_count++;
					end
					if (result_ch.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status,
							result_ch.status);
						error_count++;
					end
				end
			end
			if (long_hold) begin
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (sent_count < total_items - 150 && $urandom_range(0, 99) < 6) begin
				stall_left = $urandom_range(0, 18);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Back-pressure: hold off results long enough to fill the block
	initial begin
		wait (sent_count >= 400);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (300) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#7200000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [127:0] pool_addr [$];
		logic [7:0]   pool_len [$];
		logic [127:0] addr;
		logic [127:0] mask;
		logic [7:0]   plen;
		int           counted;
		int           span;
		int           pick;
		int           r;
		int           s;
		logic         fill_run;

		item_ch.valid = 1'b0;
		item_ch.opcode = OpClear;
		item_ch.address_high = '0;
		item_ch.address_low = '0;
		item_ch.prefix_length = '0;
		result_ch.ready = 1'b0;

		// Directed part: extremes, rejects, duplicates, mapped IPv4, zero length
		push_command(OpClear, '0, 8'd0);
		push_command(OpLookup, '0, 8'd0);
		push_command(OpAdd, random_address(), 8'd129);
		push_command(OpAdd, '1, 8'd255);
		push_command(OpAdd, '1, 8'd128);
		push_command(OpAdd, '1, 8'd128);
		push_command(OpLookup, '1, 8'd255);
		push_command(OpLookup, ~128'd1, 8'd0);
		push_command(OpAdd, '1, 8'd127);
		push_command(OpLookup, ~128'd1, 8'd128);
		push_command(OpAdd, {64'h0, 32'h0000ffff, 32'hc0a80000}, 8'd112);
		push_command(OpLookup, {64'h0, 32'h0000ffff, 32'hc0a82505}, 8'd7);
		push_command(OpLookup, {64'h0, 32'h0000ffff, 32'hc0a90001}, 8'd112);
		push_command(OpAdd, {64'h20010db8_12345678, 64'hdeadbeef_00ff00ff}, 8'd32);
		push_command(OpAdd, {64'h20010db8_00000000, 64'h0}, 8'd32);
		push_command(OpLookup, {64'h20010db8_ffffffff, 64'hffffffff_ffffffff}, 8'd1);
		push_command(OpUnused, '1, 8'hff);
		push_command(OpAdd, '0, 8'd0);
		push_command(OpLookup, random_address(), 8'd64);
		push_command(OpClear, '1, 8'hff);
		push_command(OpLookup, '1, 8'd128);
		push_command(OpAdd, '0, 8'd64);
		push_command(OpLookup, {64'h0, 64'hffffffff_ffffffff}, 8'd0);
		push_command(OpLookup, {64'h1, 64'h0}, 8'd0);

		// Random part: episodes of adds and lookups, some filling the store
		counted = 0;
		while (counted < 950) begin
			if ($urandom_range(0, 99) < 80) begin
				push_command(OpClear, random_address(), 8'($urandom));
				pool_addr.delete();
				pool_len.delete();
				counted++;
			end
			fill_run = ($urandom_range(0, 99) < 15);
			span = fill_run ? $urandom_range(90, 110) : $urandom_range(4, 40);
			for (int k = 0; k < span; k++) begin
				r = $urandom_range(0, 99);
				s = $urandom_range(0, 99);
				if (r < 2) begin
					push_command(OpUnused, random_address(), 8'($urandom));
				end else if (r < 3) begin
					push_command(OpClear, random_address(), 8'($urandom));
					pool_addr.delete();
					pool_len.delete();
					counted++;
				end else if (r < (fill_run ? 75 : 45)) begin
					if (s < 10 && pool_addr.size() > 0) begin
						pick = $urandom_range(0, pool_addr.size() - 1);
						push_command(OpAdd, pool_addr[pick], pool_len[pick]);
					end else if (s < 18) begin
						push_command(OpAdd, random_address(), 8'($urandom_range(129, 255)));
					end else begin
						addr = random_address();
						s = $urandom_range(0, 99);
						if (s < 2) begin
							plen = 8'd0;
						end else if (s < 30) begin
							plen = 8'(96 + $urandom_range(0, 32));
							addr = {64'h0, 32'h0000ffff, $urandom};
						end else if (s < 40) begin
							plen = 8'($urandom_range(120, 128));
						end else begin
							plen = 8'($urandom_range(1, 128));
						end
						push_command(OpAdd, addr, plen);
						pool_addr.push_back(addr);
						pool_len.push_back(plen);
					end
					counted++;
				end else begin
					if (pool_addr.size() > 0 && s < 70) begin
						// land inside a stored prefix, or just outside it
						pick = $urandom_range(0, pool_addr.size() - 1);
						mask = prefix_mask(pool_len[pick]);
						addr = (pool_addr[pick] & mask) | (random_address() & ~mask);
						if (s >= 55 && pool_len[pick] != 8'd0)
							addr[$urandom_range(128 - int'(pool_len[pick]), 127)] ^= 1'b1;
					end else if (s < 80) begin
						addr = {64'h0, 32'h0000ffff, $urandom};
					end else begin
						addr = random_address();
					end
					push_command(OpLookup, addr, 8'($urandom));
					counted++;
				end
			end
		end
		total_items = command_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (sent_count == total_items);
		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
